// ===== hw/rtl/lad_pkg.sv =====
package lad_pkg;

    typedef logic [2:0] t_cmd;
    typedef logic [1:0] t_status;

    localparam t_cmd CMD_PUSH_FRONT = 3'd0;
    localparam t_cmd CMD_PUSH_BACK  = 3'd1;
    localparam t_cmd CMD_POP_FRONT  = 3'd2;
    localparam t_cmd CMD_POP_BACK   = 3'd3;
    localparam t_cmd CMD_PEEK_FRONT = 3'd4;
    localparam t_cmd CMD_PEEK_BACK  = 3'd5;
    localparam t_cmd CMD_CLEAR      = 3'd6;
    localparam t_cmd CMD_SIZE       = 3'd7;

    localparam t_status ST_OK        = 2'd0;
    localparam t_status ST_OVERFLOW  = 2'd1;
    localparam t_status ST_UNDERFLOW = 2'd2;

    localparam int unsigned WORD_W  = 32;
    localparam int unsigned COUNT_W = 8;

endpackage

// ===== hw/rtl/lad_ram.sv =====
module lad_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/linear_array_deque.sv =====
// An item accepted at one edge has its result on the outputs, marked by o_done,
// during the following cycle; read data comes from the registered RAM read.
// No new item is accepted while busy is high, which it is during the result cycle.
// The receiver cannot stall: each result is shown for exactly one cycle.
// Reset (synchronous, active low) empties the deque; stored words are not cleared.
module linear_array_deque
    import lad_pkg::*;
#(
    parameter int unsigned DEPTH = 128
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    input  logic [2:0]                i_command,
    input  logic signed [WORD_W-1:0]  i_value,
    output logic                      busy,
    output logic                      o_done,
    output logic signed [WORD_W-1:0]  o_data,
    output logic [COUNT_W-1:0]        o_count,
    output logic [1:0]                o_status
);

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

    logic          r_busy;
    logic          r_empty, n_empty;
    logic [AW-1:0] r_front, n_front;
    logic [AW-1:0] r_rear,  n_rear;
    logic          r_rd_en, n_rd_en;
    logic [CW-1:0] r_count, n_count;
    t_status       r_status, n_status;

    logic          accept;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    logic [WORD_W-1:0] mem_rdata;
    t_cmd          cmd;

    assign accept = start && !r_busy;
    assign cmd    = i_command;

    always_comb begin
        n_empty   = r_empty;
        n_front   = r_front;
        n_rear    = r_rear;
        n_status  = ST_OK;
        n_rd_en   = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_raddr = r_front;
        unique case (cmd)
            CMD_PUSH_FRONT: begin
                if (r_empty) begin
                    n_empty = 1'b0;
                    n_front = '0;
                    n_rear  = '0;
                    mem_we  = 1'b1;
                end else if (r_front != '0) begin
                    n_front   = r_front - 1'b1;
                    mem_we    = 1'b1;
                    mem_waddr = r_front - 1'b1;
                end else begin
                    n_status = ST_OVERFLOW;
                end
            end
            CMD_PUSH_BACK: begin
                if (r_empty) begin
                    n_empty = 1'b0;
                    n_front = '0;
                    n_rear  = '0;
                    mem_we  = 1'b1;
                end else if (r_rear != LAST_SLOT) begin
                    n_rear    = r_rear + 1'b1;
                    mem_we    = 1'b1;
                    mem_waddr = r_rear + 1'b1;
                end else begin
                    n_status = ST_OVERFLOW;
                end
            end
            CMD_POP_FRONT, CMD_POP_BACK: begin
                if (r_empty) begin
                    n_status = ST_UNDERFLOW;
                end else begin
                    n_rd_en   = 1'b1;
                    mem_raddr = (cmd == CMD_POP_FRONT) ? r_front : r_rear;
                    if (r_front == r_rear) begin
                        n_empty = 1'b1;
                        n_front = '0;
                        n_rear  = '0;
                    end else if (cmd == CMD_POP_FRONT) begin
                        n_front = r_front + 1'b1;
                    end else begin
                        n_rear = r_rear - 1'b1;
                    end
                end
            end
            CMD_PEEK_FRONT, CMD_PEEK_BACK: begin
                if (r_empty) begin
                    n_status = ST_UNDERFLOW;
                end else begin
                    n_rd_en   = 1'b1;
                    mem_raddr = (cmd == CMD_PEEK_FRONT) ? r_front : r_rear;
                end
            end
            CMD_CLEAR: begin
                n_empty = 1'b1;
                n_front = '0;
                n_rear  = '0;
            end
            CMD_SIZE: begin
            end
            default: begin
            end
        endcase
    end

    // count after the command
    always_comb begin
        if (n_empty || (n_rear < n_front)) begin
            n_count = '0;
        end else begin
            n_count = CW'(n_rear - n_front) + CW'(1);
        end
    end

    assign mem_re = accept && n_rd_en;

    lad_ram #(
        .WIDTH(WORD_W),
        .DEPTH(DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (accept && mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (i_value),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_empty <= 1'b1;
            r_front <= '0;
            r_rear  <= '0;
            r_rd_en <= 1'b0;
        end else begin
            r_busy <= accept;
            if (accept) begin
                r_empty <= n_empty;
                r_front <= n_front;
                r_rear  <= n_rear;
                r_rd_en <= n_rd_en;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_count  <= n_count;
            r_status <= n_status;
        end
    end

    assign busy     = r_busy;
    assign o_done   = r_busy;
    assign o_data   = r_rd_en ? mem_rdata : '0;
    assign o_count  = COUNT_W'(r_count);
    assign o_status = r_status;

    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_done)
        else $error("accepted item produced no result");

    a_no_accept_in_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held for more than one cycle");

    a_empty_slots: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_empty |-> (r_front == '0) && (r_rear == '0))
        else $error("empty deque with nonzero slot indices");

    a_slot_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_empty |-> (r_front <= r_rear))
        else $error("front slot past rear slot");

    a_underflow_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status == ST_UNDERFLOW)) |-> (o_count == '0) && (o_data == '0))
        else $error("underflow result with data or count");

endmodule

// ===== test/tb_linear_array_deque.sv =====
`timescale 1ns / 100ps

module tb_linear_array_deque;
    import lad_pkg::*;

    localparam int unsigned DQ_DEPTH    = 128;
    localparam int          ITEM_TARGET = 1700;
    localparam int          IDLE_LIMIT  = 1000;
    localparam int          SHOWN_MAX   = 10;

    // Modes that shape the command mix of the random episodes
    localparam int MODE_GROW  = 0;
    localparam int MODE_SHIFT = 1;
    localparam int MODE_DRAIN = 2;
    localparam int MODE_ANY   = 3;

    typedef struct packed {
        logic signed [WORD_W-1:0] data;
        logic [COUNT_W-1:0]       count;
        t_status                  status;
    } t_reply;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     start = 1'b0;
    logic [2:0]               i_command = CMD_SIZE;
    logic signed [WORD_W-1:0] i_value = '0;
    logic                     busy;
    logic                     o_done;
    logic signed [WORD_W-1:0] o_data;
    logic [COUNT_W-1:0]       o_count;
    logic [1:0]               o_status;

    // Shadow copy of the deque
    logic signed [WORD_W-1:0] shadow_mem [DQ_DEPTH];
    int                       shadow_front = 0;
    int                       shadow_rear = 0;
    bit                       shadow_empty = 1'b1;

    t_reply awaited_replies[$];

    int items_sent = 0;
    int replies_checked = 0;
    int mismatches = 0;
    int idle_cycles = 0;
    int burst_left = 1;
    int n_overflow = 0;
    int n_underflow = 0;
    int peak_count = 0;

    linear_array_deque #(
        .DEPTH(DQ_DEPTH)
    ) u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_command(i_command),
        .i_value  (i_value),
        .busy     (busy),
        .o_done   (o_done),
        .o_data   (o_data),
        .o_count  (o_count),
        .o_status (o_status)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    function automatic int shadow_held();
        return shadow_empty ? 0 : shadow_rear - shadow_front + 1;
    endfunction

    task automatic predict_deque_cmd(input t_cmd cmd, input logic signed [WORD_W-1:0] val);
        t_reply r;
        r.data   = '0;
        r.status = ST_OK;
        case (cmd)
            CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                if (shadow_empty) begin
                    shadow_empty  = 1'b0;
                    shadow_front  = 0;
                    shadow_rear   = 0;
                    shadow_mem[0] = val;
                end else if (cmd == CMD_PUSH_FRONT && shadow_front > 0) begin
                    shadow_front--;
                    shadow_mem[shadow_front] = val;
                end else if (cmd == CMD_PUSH_BACK && shadow_rear < DQ_DEPTH - 1) begin
                    shadow_rear++;
                    shadow_mem[shadow_rear] = val;
                end else begin
                    r.status = ST_OVERFLOW;
                end
            end
            CMD_POP_FRONT, CMD_POP_BACK: begin
                if (shadow_empty) begin
                    r.status = ST_UNDERFLOW;
                end else begin
                    r.data = shadow_mem[cmd == CMD_POP_FRONT ? shadow_front : shadow_rear];
                    if (shadow_front == shadow_rear) begin
                        shadow_empty = 1'b1;
                        shadow_front = 0;
                        shadow_rear  = 0;
                    end else if (cmd == CMD_POP_FRONT) begin
                        shadow_front++;
                    end else begin
                        shadow_rear--;
                    end
                end
            end
            CMD_PEEK_FRONT, CMD_PEEK_BACK: begin
                if (shadow_empty)
                    r.status = ST_UNDERFLOW;
                else
                    r.data = shadow_mem[cmd == CMD_PEEK_FRONT ? shadow_front : shadow_rear];
            end
            CMD_CLEAR: begin
                // stored words survive a clear
                shadow_empty = 1'b1;
                shadow_front = 0;
                shadow_rear  = 0;
            end
            default: begin
            end
        endcase
        r.count = COUNT_W'(shadow_held());
        if (r.status == ST_OVERFLOW) n_overflow++;
        if (r.status == ST_UNDERFLOW) n_underflow++;
        if (shadow_held() > peak_count) peak_count = shadow_held();
        awaited_replies.insert(awaited_replies.size(), r);
    endtask

    function automatic logic signed [WORD_W-1:0] pick_value();
        case ($urandom_range(15))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2:       return '0;
            3:       return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    // Items go out in bursts; start stays high across a burst
    task automatic send_cmd(input t_cmd cmd, input logic signed [WORD_W-1:0] val);
        start     <= 1'b1;
        i_command <= cmd;
        i_value   <= val;
        do @(posedge i_clk); while (busy);
        predict_deque_cmd(cmd, val);
        items_sent++;
        burst_left--;
        if (burst_left <= 0) begin
            start     <= 1'b0;
            i_command <= t_cmd'($urandom_range(7));
            i_value   <= $urandom;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
            burst_left = ($urandom_range(5) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(1, 10);
        end
    endtask

    function automatic t_cmd pick_cmd(input int mode);
        int roll;
        roll = $urandom_range(99);
        if (mode != MODE_ANY && roll == 0) return CMD_CLEAR;
        case (mode)
            MODE_GROW: begin
                if (roll < 65) return CMD_PUSH_BACK;
                if (roll < 75) return CMD_PUSH_FRONT;
                if (roll < 85) return CMD_POP_FRONT;
                return t_cmd'($urandom_range(3, 7) == 6 ? CMD_SIZE : $urandom_range(3, 7));
            end
            MODE_SHIFT: begin
                if (roll < 40) return CMD_POP_FRONT;
                if (roll < 80) return CMD_PUSH_FRONT;
                if (roll < 90) return CMD_PUSH_BACK;
                return ($urandom_range(1) != 0) ? CMD_PEEK_FRONT : CMD_PEEK_BACK;
            end
            MODE_DRAIN: begin
                if (roll < 35) return CMD_POP_FRONT;
                if (roll < 70) return CMD_POP_BACK;
                if (roll < 80) return CMD_PUSH_BACK;
                return t_cmd'($urandom_range(4, 7) == 6 ? CMD_PEEK_BACK : $urandom_range(4, 7));
            end
            default: return t_cmd'($urandom_range(7));
        endcase
    endfunction

    task automatic test_empty_and_edges();
        send_cmd(CMD_SIZE, pick_value());
        send_cmd(CMD_POP_FRONT, pick_value());
        send_cmd(CMD_POP_BACK, pick_value());
        send_cmd(CMD_PEEK_FRONT, pick_value());
        send_cmd(CMD_PEEK_BACK, pick_value());
        send_cmd(CMD_PUSH_FRONT, 32'sh7fff_ffff);
        send_cmd(CMD_PUSH_FRONT, -32'sd1);  // front already at slot 0
        send_cmd(CMD_PEEK_FRONT, '0);
        send_cmd(CMD_PUSH_BACK, 32'sh8000_0000);
        send_cmd(CMD_PUSH_BACK, '0);
        send_cmd(CMD_PEEK_BACK, -32'sd1);
        send_cmd(CMD_POP_FRONT, '0);
        send_cmd(CMD_PUSH_FRONT, 32'sh5555_5555);
        send_cmd(CMD_PUSH_FRONT, 32'sh2aaa_aaaa);
        send_cmd(CMD_POP_BACK, '0);
        send_cmd(CMD_POP_BACK, '0);
        send_cmd(CMD_POP_BACK, '0);         // takes the last entry
        send_cmd(CMD_POP_BACK, '0);
        send_cmd(CMD_PUSH_BACK, 32'shaaaa_aaaa);
        send_cmd(CMD_PUSH_BACK, 32'sd1);
        send_cmd(CMD_CLEAR, 32'sh1234_5678);
        send_cmd(CMD_SIZE, '0);
        send_cmd(CMD_PEEK_FRONT, '0);
        send_cmd(CMD_PUSH_FRONT, -32'sd2);
        send_cmd(CMD_PEEK_BACK, '0);
    endtask

    task automatic test_fill_and_overflow();
        send_cmd(CMD_CLEAR, pick_value());
        repeat (DQ_DEPTH) send_cmd(CMD_PUSH_BACK, pick_value());
        send_cmd(CMD_PUSH_BACK, pick_value());
        send_cmd(CMD_PUSH_FRONT, pick_value());
        send_cmd(CMD_SIZE, pick_value());
        repeat (DQ_DEPTH / 2) send_cmd(CMD_POP_FRONT, pick_value());
        repeat (DQ_DEPTH / 2 + 1) send_cmd(CMD_PUSH_FRONT, pick_value());
        repeat (DQ_DEPTH + 1) send_cmd(CMD_POP_BACK, pick_value());
    endtask

    task automatic test_random_episodes();
        int mode;
        int len;
        while (items_sent < ITEM_TARGET) begin
            mode = $urandom_range(MODE_ANY);
            len  = $urandom_range(20, 160);
            repeat (len) send_cmd(pick_cmd(mode), pick_value());
        end
    endtask

    task automatic note_mismatch(input string what, input logic [WORD_W-1:0] want,
                                 input logic [WORD_W-1:0] got);
        mismatches++;
        if (mismatches <= SHOWN_MAX)
            $display("%0t: %s mismatch: expected %0h, got %0h", $realtime, what, want, got);
    endtask

    always @(posedge i_clk) begin
        t_reply w;
        if (i_rst_n && o_done) begin
            if (awaited_replies.size() == 0) begin
                note_mismatch("unexpected result, data", '0, o_data);
            end else begin
                w = awaited_replies[0];
                awaited_replies.delete(0);
                replies_checked++;
                if (o_data !== w.data) note_mismatch("data", w.data, o_data);
                if (o_count !== w.count)
                    note_mismatch("count", WORD_W'(w.count), WORD_W'(o_count));
                if (o_status !== w.status)
                    note_mismatch("status", WORD_W'(w.status), WORD_W'(o_status));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        foreach (shadow_mem[k]) shadow_mem[k] = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_and_edges();
        test_fill_and_overflow();
        test_random_episodes();

        start <= 1'b0;
        while (awaited_replies.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (awaited_replies.size() != 0) note_mismatch("missing results", 0, 0);

        $display("%0d commands sent, %0d results checked, %0d mismatches",
                 items_sent, replies_checked, mismatches);
        $display("%0d overflows, %0d underflows, peak occupancy %0d of %0d",
                 n_overflow, n_underflow, peak_count, DQ_DEPTH);
        if (mismatches == 0 && replies_checked == items_sent) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
